### hdl/ima_pkg.sv
`timescale 1ns / 1ps
// types, constants and lookup tables shared by the adpcm decoder modules
package ima_pkg;

    localparam logic [6:0] IDX_MAX = 7'd88;
    localparam logic signed [17:0] PRED_MAX = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN = -18'sd32768;

    typedef struct packed {
        logic       action;
        logic [7:0] code_byte;
    } code_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic               last;
    } pcm_item_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_STEREO,
        OP_MONO
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] first_code;
        logic [3:0] second_code;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        begin
            unique case (idx)
                7'd0:  s = 15'd7;
                7'd1:  s = 15'd8;
                7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;
                7'd4:  s = 15'd11;
                7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;
                7'd7:  s = 15'd14;
                7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;
                7'd10: s = 15'd19;
                7'd11: s = 15'd21;
                7'd12: s = 15'd23;
                7'd13: s = 15'd25;
                7'd14: s = 15'd28;
                7'd15: s = 15'd31;
                7'd16: s = 15'd34;
                7'd17: s = 15'd37;
                7'd18: s = 15'd41;
                7'd19: s = 15'd45;
                7'd20: s = 15'd50;
                7'd21: s = 15'd55;
                7'd22: s = 15'd60;
                7'd23: s = 15'd66;
                7'd24: s = 15'd73;
                7'd25: s = 15'd80;
                7'd26: s = 15'd88;
                7'd27: s = 15'd97;
                7'd28: s = 15'd107;
                7'd29: s = 15'd118;
                7'd30: s = 15'd130;
                7'd31: s = 15'd143;
                7'd32: s = 15'd157;
                7'd33: s = 15'd173;
                7'd34: s = 15'd190;
                7'd35: s = 15'd209;
                7'd36: s = 15'd230;
                7'd37: s = 15'd253;
                7'd38: s = 15'd279;
                7'd39: s = 15'd307;
                7'd40: s = 15'd337;
                7'd41: s = 15'd371;
                7'd42: s = 15'd408;
                7'd43: s = 15'd449;
                7'd44: s = 15'd494;
                7'd45: s = 15'd544;
                7'd46: s = 15'd598;
                7'd47: s = 15'd658;
                7'd48: s = 15'd724;
                7'd49: s = 15'd796;
                7'd50: s = 15'd876;
                7'd51: s = 15'd963;
                7'd52: s = 15'd1060;
                7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;
                7'd55: s = 15'd1411;
                7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;
                7'd58: s = 15'd1878;
                7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;
                7'd61: s = 15'd2499;
                7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;
                7'd64: s = 15'd3327;
                7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;
                7'd67: s = 15'd4428;
                7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;
                7'd70: s = 15'd5894;
                7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;
                7'd73: s = 15'd7845;
                7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;
                7'd76: s = 15'd10442;
                7'd77: s = 15'd11487;
                7'd78: s = 15'd12635;
                7'd79: s = 15'd13899;
                7'd80: s = 15'd15289;
                7'd81: s = 15'd16818;
                7'd82: s = 15'd18500;
                7'd83: s = 15'd20350;
                7'd84: s = 15'd22385;
                7'd85: s = 15'd24623;
                7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [3:0] code);
        logic signed [4:0] a;
        begin
            unique case (code[2:0])
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

endpackage

### hdl/ima_adpcm_decoder.sv
`timescale 1ns / 1ps
// a byte is queued, then its two samples are registered in turn in the output register
// a single nibble decoder serves both codes in turn; the next byte waits for both
// a clear transaction takes the decoder's turn and produces no sample
// the queue holds QUEUE_DEPTH transactions and takes input while output stalls, until full
// reset clears the mode register, all predictors and step indices, and the queue
module ima_adpcm_decoder
    import ima_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       code_valid,
    output logic       code_stall,
    input  code_item_t code_data,
    output logic       pcm_valid,
    input  logic       pcm_stall,
    output pcm_item_t  pcm_data
);

    logic    stereo_mode_reg;
    q_head_t head;
    logic    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            stereo_mode_reg <= cfg_data;
        end
    end

    ima_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .stereo_mode (stereo_mode_reg),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .code_data   (code_data),
        .head        (head),
        .pop         (pop)
    );

    ima_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .pcm_valid (pcm_valid),
        .pcm_stall (pcm_stall),
        .pcm_data  (pcm_data)
    );

endmodule

### hdl/ima_front.sv
`timescale 1ns / 1ps
// front end: accepts transactions, classifies them and queues them for the back end
module ima_front
    import ima_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       stereo_mode,
    input  logic       code_valid,
    output logic       code_stall,
    input  code_item_t code_data,
    output q_head_t    head,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    q_entry_t         new_entry;
    logic             push;

    assign code_stall = (count_reg == CNT_FULL);
    assign push       = code_valid && !code_stall;

    always_comb
    begin
        if (code_data.action)
        begin
            new_entry.op = OP_CLEAR;
        end
        else if (stereo_mode)
        begin
            new_entry.op = OP_STEREO;
        end
        else
        begin
            new_entry.op = OP_MONO;
        end
        if (stereo_mode)
        begin
            new_entry.first_code  = code_data.code_byte[3:0];
            new_entry.second_code = code_data.code_byte[7:4];
        end
        else
        begin
            new_entry.first_code  = code_data.code_byte[7:4];
            new_entry.second_code = code_data.code_byte[3:0];
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

### hdl/ima_back.sv
`timescale 1ns / 1ps
// back end: applies clears, decodes via the nibble decoder into the output register
module ima_back
    import ima_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_head_t   head,
    output logic      pop,
    output logic      pcm_valid,
    input  logic      pcm_stall,
    output pcm_item_t pcm_data
);

    phase_t             phase_reg, phase_next;
    logic [6:0]         st_idx_reg [2];
    logic signed [15:0] st_pred_reg [2];
    logic [6:0]         mono_idx_reg;
    logic signed [15:0] mono_pred_reg;
    logic               pcm_valid_reg, pcm_valid_next;
    pcm_item_t          pcm_data_reg;

    logic               out_free;
    logic               exec_clear;
    logic               exec_dec;
    logic               is_stereo;
    logic               ch;
    logic [3:0]         code;
    logic [6:0]         cur_idx;
    logic [6:0]         idx_clamp;
    logic signed [15:0] cur_pred;
    logic [14:0]        step;
    logic signed [7:0]  ni;
    logic [6:0]         new_idx;
    logic [16:0]        diff;
    logic signed [17:0] p;
    logic signed [15:0] new_pred;

    assign out_free   = !pcm_valid_reg || !pcm_stall;
    assign exec_clear = head.valid && (head.entry.op == OP_CLEAR);
    assign exec_dec   = head.valid && (head.entry.op != OP_CLEAR) && out_free;
    assign is_stereo  = (head.entry.op == OP_STEREO);

    always_comb
    begin
        phase_next = phase_reg;
        pop        = exec_clear;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (exec_dec)
                begin
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (exec_dec)
                begin
                    phase_next = PH_FIRST;
                    pop        = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // nibble decode datapath
    always_comb
    begin
        code     = (phase_reg == PH_FIRST) ? head.entry.first_code : head.entry.second_code;
        ch       = is_stereo && (phase_reg == PH_SECOND);
        cur_idx  = is_stereo ? st_idx_reg[ch] : mono_idx_reg;
        cur_pred = is_stereo ? st_pred_reg[ch] : mono_pred_reg;

        idx_clamp = (cur_idx > IDX_MAX) ? IDX_MAX : cur_idx;
        step      = step_size(idx_clamp);

        ni = $signed({1'b0, idx_clamp}) + 8'(index_adjust(code));
        if (ni < 0)
        begin
            new_idx = '0;
        end
        else if (ni > $signed({1'b0, IDX_MAX}))
        begin
            new_idx = IDX_MAX;
        end
        else
        begin
            new_idx = ni[6:0];
        end

        diff = 17'(step >> 3);
        if (code[2])
        begin
            diff = diff + 17'(step);
        end
        if (code[1])
        begin
            diff = diff + 17'(step >> 1);
        end
        if (code[0])
        begin
            diff = diff + 17'(step >> 2);
        end

        if (code[3])
        begin
            p = 18'(cur_pred) - $signed({1'b0, diff});
        end
        else
        begin
            p = 18'(cur_pred) + $signed({1'b0, diff});
        end

        if (p > PRED_MAX)
        begin
            new_pred = PRED_MAX[15:0];
        end
        else if (p < PRED_MIN)
        begin
            new_pred = PRED_MIN[15:0];
        end
        else
        begin
            new_pred = p[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_idx_reg[0]  <= '0;
            st_idx_reg[1]  <= '0;
            st_pred_reg[0] <= '0;
            st_pred_reg[1] <= '0;
            mono_idx_reg   <= '0;
            mono_pred_reg  <= '0;
        end
        else if (exec_clear)
        begin
            st_idx_reg[0]  <= '0;
            st_idx_reg[1]  <= '0;
            st_pred_reg[0] <= '0;
            st_pred_reg[1] <= '0;
        end
        else if (exec_dec)
        begin
            if (is_stereo)
            begin
                st_idx_reg[ch]  <= new_idx;
                st_pred_reg[ch] <= new_pred;
            end
            else
            begin
                mono_idx_reg  <= new_idx;
                mono_pred_reg <= new_pred;
            end
        end
    end

    // output register
    always_comb
    begin
        if (exec_dec)
        begin
            pcm_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            pcm_valid_next = 1'b0;
        end
        else
        begin
            pcm_valid_next = pcm_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcm_valid_reg <= 1'b0;
        end
        else
        begin
            pcm_valid_reg <= pcm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_dec)
        begin
            pcm_data_reg.sample  <= new_pred;
            pcm_data_reg.channel <= ch;
            pcm_data_reg.last    <= (phase_reg == PH_SECOND);
        end
    end

    assign pcm_valid = pcm_valid_reg;
    assign pcm_data  = pcm_data_reg;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        exec_clear |=> st_pred_reg[0] == '0 && st_pred_reg[1] == '0
                       && st_idx_reg[0] == '0 && st_idx_reg[1] == '0)
        else $error("clear did not zero stereo state");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_idx_reg[0] <= IDX_MAX && st_idx_reg[1] <= IDX_MAX && mono_idx_reg <= IDX_MAX)
        else $error("step index out of range");

    a_mid_byte_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SECOND |-> head.valid && head.entry.op != OP_CLEAR)
        else $error("queue head changed in the middle of a byte");

    a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
        exec_dec && phase_reg == PH_SECOND |=> pcm_valid_reg && pcm_data_reg.last)
        else $error("second sample not flagged last");

endmodule
